### hdl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared constants, types and helpers for the palindrome word counter.
// ----------------------------------------------------------------------------
package pwc_pkg;

    // Default word buffer depth
    localparam int MAX_WORD_DEF = 64;

    // Byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SUB    = 8'h1A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the input beat
        logic rd;       // read the current buffer pair
        logic cmp;      // compare the pair read last cycle
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_cmp; // accepted beat closes a word that needs the mirror check
        logic cmp_last; // this compare ends the check
        logic out_busy; // result register holds a beat that is not taken now
    } t_sts;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_PERIOD) || (c == CH_COMMA) || (c == CH_LF);
    endfunction

    function automatic logic is_dropped(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SUB);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? 8'(c + CASE_OFS) : c;
    endfunction

endpackage

### hdl/pwc_ram.sv
// ----------------------------------------------------------------------------
// pwc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hdl/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl
// Sequencer: accepts beats and walks the mirror check read/compare loop.
// ----------------------------------------------------------------------------
module pwc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pwc_pkg::t_sts i_sts,
    output pwc_pkg::t_cmd o_cmd
);
    import pwc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // Input is taken only when idle and the result register is free
    assign o_in_ready = (r_state == ST_IDLE) && !i_sts.out_busy;
    assign accept     = o_in_ready && i_in_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = accept;
                if (accept && i_sts.need_cmp) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.cmp_last ? ST_IDLE : ST_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/pwc_dp.sv
// ----------------------------------------------------------------------------
// pwc_dp
// Datapath: word buffer, length/overflow tracking, pair compare, counter,
// and the result register.
// ----------------------------------------------------------------------------
module pwc_dp #(
    parameter int MAX_WORD = pwc_pkg::MAX_WORD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pwc_pkg::t_cmd i_cmd,
    output pwc_pkg::t_sts o_sts,
    input  logic [7:0]    i_char_in,
    input  logic          i_end_of_stream,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [31:0]   o_palindrome_count,
    output logic          o_word_ended,
    output logic          o_word_was_palindrome,
    output logic          o_word_too_long
);
    import pwc_pkg::*;

    localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LW = $clog2(MAX_WORD + 1);

    // Control state
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic [31:0]   r_count;
    logic          r_out_valid;
    // Payload
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic          r_ended;
    logic          r_pal;
    logic          r_too_long;

    logic [7:0]    ch_fold;
    logic          is_word;
    logic          buf_full;
    logic          wr_en;
    logic [LW-1:0] len_app;
    logic          ovf_app;
    logic          ended;
    logic          need_cmp;
    logic [7:0]    rd_a;
    logic [7:0]    rd_b;
    logic          match;
    logic [AW-1:0] i_next;
    logic [AW-1:0] j_next;
    logic          cmp_last;
    logic          finish_cmp;
    logic          set_out;

    // Classify the incoming byte and update the open word
    always_comb begin
        ch_fold  = fold_case(i_char_in);
        is_word  = !is_dropped(i_char_in) && !is_delim(i_char_in);
        buf_full = (r_len == LW'(MAX_WORD));
        wr_en    = i_cmd.accept && is_word && !buf_full;
        len_app  = wr_en ? LW'(r_len + LW'(1)) : r_len;
        ovf_app  = r_ovf || (is_word && buf_full);
        ended    = (is_delim(i_char_in) || i_end_of_stream) && ((len_app != '0) || ovf_app);
        need_cmp = ended && !ovf_app && (len_app >= LW'(2));
    end

    // Pair compare; stop on mismatch or when the indices meet
    always_comb begin
        match      = (rd_a == rd_b);
        i_next     = AW'(r_i + AW'(1));
        j_next     = AW'(r_j - AW'(1));
        cmp_last   = !match || !(i_next < j_next);
        finish_cmp = i_cmd.cmp && cmp_last;
        set_out    = (i_cmd.accept && !need_cmp) || finish_cmp;
    end

    assign o_sts.need_cmp = need_cmp;
    assign o_sts.cmp_last = cmp_last;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    pwc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (r_len[AW-1:0]),
        .i_wdata   (ch_fold),
        .i_re      (i_cmd.rd),
        .i_raddr_a (r_i),
        .i_raddr_b (r_j),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Word length, overflow, counter, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_len <= ended ? '0 : len_app;
                r_ovf <= ended ? 1'b0 : ovf_app;
            end
            if (finish_cmp && match && (r_count != '1)) begin
                r_count <= r_count + 32'd1;
            end
            if (set_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Compare indices and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_i        <= '0;
            r_j        <= AW'(len_app - LW'(1));
            r_ended    <= ended;
            r_pal      <= 1'b0;
            r_too_long <= ended && ovf_app;
        end else if (i_cmd.cmp) begin
            r_i <= i_next;
            r_j <= j_next;
            if (cmp_last) begin
                r_pal <= match;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_palindrome_count    = r_count;
    assign o_word_ended          = r_ended;
    assign o_word_was_palindrome = r_pal;
    assign o_word_too_long       = r_too_long;

endmodule

### hdl/palindrome_word_counter_core.sv
// ----------------------------------------------------------------------------
// palindrome_word_counter_core
// Counts palindrome words in a byte stream; one result beat per input beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  input    in         i_in_valid / o_in_ready     i_char_in, i_end_of_stream
//  result   out        o_out_valid / i_out_ready   o_palindrome_count, o_word_ended,
//                                                  o_word_was_palindrome, o_word_too_long
//
// A beat that does not close a checkable word sets its result directly. A beat that
// closes a word of L >= 2 characters runs the read/compare loop on the word buffer
// RAM over K <= L/2 compared pairs before its result is set.
// Reset is synchronous, active low; the buffer needs no clearing.
// The input is held off while a result beat is waiting and not taken.
// ----------------------------------------------------------------------------
module palindrome_word_counter_core #(
    parameter int MAX_WORD = pwc_pkg::MAX_WORD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_palindrome_count,
    output logic        o_word_ended,
    output logic        o_word_was_palindrome,
    output logic        o_word_too_long
);
    import pwc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pwc_dp #(
        .MAX_WORD (MAX_WORD)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_char_in             (i_char_in),
        .i_end_of_stream       (i_end_of_stream),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_palindrome_count    (o_palindrome_count),
        .o_word_ended          (o_word_ended),
        .o_word_was_palindrome (o_word_was_palindrome),
        .o_word_too_long       (o_word_too_long)
    );

endmodule
